[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Shadow table assertion macros
// Assertion macros used by the checker module of the shadow table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QCST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define QCST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/qcst_pkg.sv]
// ----------------------------------------------------------------------------
// Qubit classical shadow table package
// Item types, command and error codes shared by the table and its checker.
// ----------------------------------------------------------------------------
package qcst_pkg;

  localparam int ENTRY_COUNT = 1024;

  localparam logic [2:0] CMD_NOT     = 3'd0;
  localparam logic [2:0] CMD_CNOT    = 3'd1;
  localparam logic [2:0] CMD_TOFFOLI = 3'd2;
  localparam logic [2:0] CMD_ROTATE  = 3'd3;
  localparam logic [2:0] CMD_RETIRE  = 3'd4;
  localparam logic [2:0] CMD_GROW    = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RANGE    = 2'd1;
  localparam logic [1:0] ERR_RETIRE   = 2'd2;
  localparam logic [1:0] ERR_CAPACITY = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  target_index;
    logic [9:0]  control_a_index;
    logic [9:0]  control_b_index;
    logic [10:0] new_count;
  } cmd_item_t;

  typedef struct packed {
    logic        value_bit;
    logic        unknown_bit;
    logic        known_zero;
    logic [1:0]  error_code;
    logic [10:0] active_count;
  } rsp_item_t;

  // Entry layout: {unknown, value}.
  typedef logic [1:0] entry_t;

endpackage

[rtl/qubit_classical_shadow_table_top.sv]
// ----------------------------------------------------------------------------
// Qubit classical shadow table
// Tracks a known/unknown value per qubit and applies one gate command per item.
// ----------------------------------------------------------------------------
// After reset the block clears its entry store, one entry per cycle, and
// stalls commands until the sweep is done. From then on it takes one command
// per cycle while the output is not stalled: the entries named by a command
// are read from the store at the edge that accepts it, the update is worked
// out while the command is held in stage one and written back at the edge
// that moves the result into the output register. Three copies of the store
// give the three read ports; each copy has one write and one read port.
// Errors leave the table and the active count unchanged.
module qubit_classical_shadow_table_top #(
  parameter int ENTRY_COUNT = qcst_pkg::ENTRY_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  qcst_pkg::cmd_item_t   cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output qcst_pkg::rsp_item_t   rsp
);

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRY_COUNT - 1);
  localparam logic [31:0] CAPACITY = 32'(ENTRY_COUNT);

  qcst_pkg::entry_t store_t [ENTRY_COUNT];
  qcst_pkg::entry_t store_a [ENTRY_COUNT];
  qcst_pkg::entry_t store_b [ENTRY_COUNT];

  logic                clearing;
  logic [AW-1:0]       clr_addr;
  logic [10:0]         count;
  logic [10:0]         count_next;

  logic                s1_valid;
  qcst_pkg::cmd_item_t s1;
  qcst_pkg::entry_t    rd_t;
  qcst_pkg::entry_t    rd_a;
  qcst_pkg::entry_t    rd_b;

  logic                rsp_next_valid;
  qcst_pkg::rsp_item_t rsp_next;

  logic                s1_advance;
  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  qcst_pkg::entry_t    wr_data;
  logic                upd_en;
  qcst_pkg::entry_t    upd_data;

  logic [AW-1:0]       addr_t;
  logic [AW-1:0]       addr_a;
  logic [AW-1:0]       addr_b;

  assign s1_advance = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall  = clearing || (s1_valid && !s1_advance);
  assign accept     = cmd_valid && !cmd_stall;

  // Out-of-range indices never reach the store with a meaningful read.
  assign addr_t = AW'(cmd.target_index);
  assign addr_a = AW'(cmd.control_a_index);
  assign addr_b = AW'(cmd.control_b_index);

  // Gate evaluation for the item held in stage one.
  always_comb begin
    logic tv;
    logic tu;
    logic t_bad;
    logic a_bad;
    logic b_bad;
    logic uses_a;
    logic uses_b;
    tv = rd_t[0];
    tu = rd_t[1];
    uses_a = (s1.command == qcst_pkg::CMD_CNOT) || (s1.command == qcst_pkg::CMD_TOFFOLI);
    uses_b = (s1.command == qcst_pkg::CMD_TOFFOLI);
    t_bad = {1'b0, s1.target_index} >= count;
    a_bad = uses_a && ({1'b0, s1.control_a_index} >= count);
    b_bad = uses_b && ({1'b0, s1.control_b_index} >= count);

    count_next = count;
    upd_en = 1'b0;
    rsp_next.value_bit = 1'b0;
    rsp_next.unknown_bit = 1'b1;
    rsp_next.known_zero = 1'b0;
    rsp_next.error_code = qcst_pkg::ERR_OK;

    if (s1.command == qcst_pkg::CMD_GROW) begin
      if ({21'b0, s1.new_count} > CAPACITY) begin
        rsp_next.error_code = qcst_pkg::ERR_CAPACITY;
      end else if (s1.new_count > count) begin
        count_next = s1.new_count;
      end
    end else if (t_bad || a_bad || b_bad) begin
      rsp_next.error_code = qcst_pkg::ERR_RANGE;
    end else begin
      case (s1.command)
        qcst_pkg::CMD_NOT: begin
          if (!tu) tv = !tv;
        end
        qcst_pkg::CMD_CNOT: begin
          tu = tu | rd_a[1];
          if (!tu) tv = tv ^ rd_a[0];
        end
        qcst_pkg::CMD_TOFFOLI: begin
          tu = tu | rd_a[1] | rd_b[1];
          if (!tu) tv = tv ^ (rd_a[0] & rd_b[0]);
        end
        qcst_pkg::CMD_ROTATE: begin
          tu = 1'b1;
        end
        qcst_pkg::CMD_RETIRE: begin
          // A known one cannot be retired; report the entry as it stands.
          if (!tu && tv) begin
            rsp_next.error_code = qcst_pkg::ERR_RETIRE;
          end else begin
            tv = 1'b0;
            tu = 1'b0;
          end
        end
        default: begin
        end
      endcase
      rsp_next.value_bit = tv;
      rsp_next.unknown_bit = tu;
      rsp_next.known_zero = !tu && !tv;
      upd_en = (rsp_next.error_code == qcst_pkg::ERR_OK);
    end
    rsp_next.active_count = count_next;
    upd_data = {tu, tv};
  end

  assign rsp_next_valid = s1_advance;
  assign wr_en   = clearing || (s1_advance && upd_en);
  assign wr_addr = clearing ? clr_addr : AW'(s1.target_index);
  assign wr_data = clearing ? 2'b00 : upd_data;

  // Each copy reads write-first, so a command right behind a write sees it.
  always_ff @(posedge clk) begin
    if (wr_en) store_t[wr_addr] <= wr_data;
    if (accept) rd_t <= (wr_en && wr_addr == addr_t) ? wr_data : store_t[addr_t];
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_a[wr_addr] <= wr_data;
    if (accept) rd_a <= (wr_en && wr_addr == addr_a) ? wr_data : store_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_b[wr_addr] <= wr_data;
    if (accept) rd_b <= (wr_en && wr_addr == addr_b) ? wr_data : store_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      count <= '0;
      s1_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) clearing <= 1'b0;
      end
      if (s1_advance) count <= count_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (rsp_next_valid) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= cmd;
    if (rsp_next_valid) rsp <= rsp_next;
  end

endmodule

[rtl/qcst_checker.sv]
// ----------------------------------------------------------------------------
// Qubit classical shadow table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qcst_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input qcst_pkg::cmd_item_t cmd,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input qcst_pkg::rsp_item_t rsp
);

  // The store is swept right after reset, so commands must wait.
  `QCST_ASSERT_NOW(a_clear_after_reset, clk, rst, $past(rst), cmd_stall)

  // A stalled result is held until it is taken.
  `QCST_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp))

  // Range and capacity errors report an unknown entry and no known zero.
  `QCST_ASSERT_NOW(a_err_report, clk, rst,
                   rsp_valid && (rsp.error_code == qcst_pkg::ERR_RANGE ||
                                 rsp.error_code == qcst_pkg::ERR_CAPACITY),
                   rsp.unknown_bit && !rsp.value_bit && !rsp.known_zero)

  // The active count never shrinks from one taken result to the next shown.
  `QCST_ASSERT_NEXT(a_count_grows, clk, rst, rsp_valid && !rsp_stall,
                    !rsp_valid || rsp.active_count >= $past(rsp.active_count))

endmodule

bind qubit_classical_shadow_table_top qcst_checker u_qcst_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
